/* rtl/anxb_pkg.sv */
// Shared types and constants for the Annex B NAL unit scanner.
// No dependencies; imported by annexb_nal_unit_scanner.
package anxb_pkg;

  // Width of the saturating counted-unit ordinal
  localparam int ORD_W = 16;
  // Width used for the window compare, wide enough for ordinal and window regs
  localparam int WIN_W = (ORD_W > 16) ? ORD_W : 16;

  // Byte-wise widths of the stream words
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  // Pending-word queue between the delay line and the output stage
  localparam int QDEPTH = 4;

  // Header layout selector
  typedef enum logic [1:0] {
    LAYOUT_AVC  = 2'd0,
    LAYOUT_HEVC = 2'd1,
    LAYOUT_VVC  = 2'd2,
    LAYOUT_NONE = 2'd3
  } codec_e_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CODEC     = 2'd0,
    REG_VCL_ONLY  = 2'd1,
    REG_WIN_START = 2'd2,
    REG_WIN_LEN   = 2'd3
  } cfg_reg_t;

  // Header byte offsets from the first zero of the start code
  localparam logic [2:0] HDR_OFF_SHORT = 3'd3;
  localparam logic [2:0] HDR_OFF_VVC   = 3'd4;
  localparam logic [2:0] APS_OFF_VVC   = 3'd5;
  localparam logic [2:0] OFF_MAX       = 3'd7;

  // Slice type limits and VVC adaptation parameter set types
  localparam logic [5:0] AVC_SLICE_LIM = 6'd6;
  localparam logic [5:0] VVC_SLICE_LIM = 6'd12;
  localparam logic [5:0] VVC_APS_PRE   = 6'd17;
  localparam logic [5:0] VVC_APS_SUF   = 6'd18;

  // One byte waiting to be tagged
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       final_b;
  } q_entry_t;

endpackage

/* rtl/annexb_nal_unit_scanner.sv */
// Annex B NAL unit scanner: start code detection, header decode, unit window.
// Depends on anxb_pkg (rtl/anxb_pkg.sv).
//
//  channel | dir | handshake               | content
//  --------+-----+-------------------------+-------------------------------------
//  in_     | in  | in_tvalid / in_tready   | stream byte, tlast = stream end
//  out_    | out | out_tvalid / out_tready | tagged byte word, tlast = final word
//  cfg_    | in  | cfg_valid / cfg_ready   | register index and write data
//
// One byte per cycle in and one word per cycle out in steady state. A byte
// enters a two-byte lookahead line and a four-entry queue; a word is written
// to the output register when it pops from the queue head. The end-of-stream
// byte flushes up to three words from the lookahead line into the queue.
// Reset is synchronous, active low; cfg_ready is always high.
// Output stalls fill the queue; in_tready drops once two words are pending.
module annexb_nal_unit_scanner (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [7:0] stream_byte
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [anxb_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  // out_tdata: [7:0] out_byte, [8] unit_start, [9] before_first_unit,
  //   [25:10] unit_ordinal, [26] inside_window, [27] type_known,
  //   [33:28] unit_type, [34] video_slice, [35] param_set_flag,
  //   [36] aps_known, [44:37] aps_ident, [47:45] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [anxb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_data
);
  import anxb_pkg::*;

  localparam logic [ORD_W-1:0] ORD_SAT = {ORD_W{1'b1}};

  // Configuration registers
  codec_e_t    codec_r;
  logic        vcl_only_r;
  logic [15:0] win_start_r;
  logic [15:0] win_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r     <= LAYOUT_AVC;
      vcl_only_r  <= 1'b0;
      win_start_r <= 16'd0;
      win_len_r   <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CODEC:     codec_r     <= codec_e_t'(cfg_data[1:0]);
        REG_VCL_ONLY:  vcl_only_r  <= cfg_data[0];
        REG_WIN_START: win_start_r <= cfg_data;
        REG_WIN_LEN:   win_len_r   <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Lookahead line: up to two held bytes plus the incoming one
  // ---------------------------------------------------------------------
  logic [7:0] d0_r, d1_r;
  logic [1:0] fill_r;
  logic [7:0] d0_nxt, d1_nxt;
  logic [1:0] fill_nxt;
  logic       in_acc;

  logic [7:0] b0, b1, b2;
  logic [1:0] nbytes;
  logic [1:0] push_n;
  logic       start0;
  q_entry_t   ent [3];

  logic [2:0] q_cnt_r;
  assign in_tready = (q_cnt_r <= 3'd1);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    b0 = in_tdata;
    b1 = in_tdata;
    b2 = in_tdata;
    unique case (fill_r)
      2'd1: begin
        b0 = d0_r;
        nbytes = 2'd2;
      end
      2'd2: begin
        b0 = d0_r;
        b1 = d1_r;
        nbytes = 2'd3;
      end
      default: nbytes = 2'd1;
    endcase

    // only the oldest byte has a full lookahead
    start0 = (nbytes == 2'd3) && (b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h01);

    if (in_tlast) begin
      push_n = nbytes;
    end else begin
      push_n = (nbytes == 2'd3) ? 2'd1 : 2'd0;
    end
    if (!in_acc) begin
      push_n = 2'd0;
    end

    ent[0] = '{data: b0, start: start0, final_b: in_tlast && (push_n == 2'd1)};
    ent[1] = '{data: b1, start: 1'b0,   final_b: in_tlast && (push_n == 2'd2)};
    ent[2] = '{data: b2, start: 1'b0,   final_b: in_tlast && (push_n == 2'd3)};

    // advance the line
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    fill_nxt = fill_r;
    if (in_acc) begin
      priority if (in_tlast) begin
        fill_nxt = 2'd0;
      end else if (nbytes == 2'd3) begin
        d0_nxt = d1_r;
        d1_nxt = in_tdata;
      end else if (nbytes == 2'd2) begin
        d1_nxt   = in_tdata;
        fill_nxt = 2'd2;
      end else begin
        d0_nxt   = in_tdata;
        fill_nxt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  // ---------------------------------------------------------------------
  // Pending queue: shift register, head at slot 0
  // ---------------------------------------------------------------------
  q_entry_t   q_slot_r [QDEPTH];
  q_entry_t   q_slot_nxt [QDEPTH];
  logic [2:0] q_cnt_nxt;
  logic [2:0] q_mid;
  logic       pop;
  logic       out_valid_r;

  assign pop = (q_cnt_r != 3'd0) && (!out_valid_r || out_tready);

  always_comb begin
    q_mid = q_cnt_r - {2'd0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        q_slot_nxt[i] = q_slot_r[(i < QDEPTH - 1) ? i + 1 : i];
      end else begin
        q_slot_nxt[i] = q_slot_r[i];
      end
      for (int k = 0; k < 3; k++) begin
        if ((3'(k) < {1'b0, push_n}) && ((q_mid + 3'(k)) == 3'(i))) begin
          q_slot_nxt[i] = ent[k];
        end
      end
    end
    q_cnt_nxt = q_mid + {1'b0, push_n};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 3'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
    q_slot_r <= q_slot_nxt;
  end

  // ---------------------------------------------------------------------
  // Unit tracking and header decode for the head word
  // ---------------------------------------------------------------------
  logic             prefix_r, slice_r, aps_r;
  logic [2:0]       off_r;
  logic [ORD_W-1:0] cnt_r;
  logic             prefix_nxt, slice_nxt, aps_nxt;
  logic [2:0]       off_nxt;
  logic [ORD_W-1:0] cnt_nxt;
  q_entry_t         e;
  logic [2:0]       hdr_off;
  logic             type_known, vslice, ps_flag, aps_known, in_win;
  logic [5:0]       utype;
  logic [7:0]       aps_id;
  logic [WIN_W:0]   cnt_ext, ws_ext, wl_ext, win_diff;
  logic [15:0]      ord16;

  always_comb begin
    e          = q_slot_r[0];
    prefix_nxt = prefix_r;
    off_nxt    = off_r;
    cnt_nxt    = cnt_r;
    slice_nxt  = slice_r;
    aps_nxt    = aps_r;

    // start code closes the previous unit
    if (e.start) begin
      if (!prefix_r && (!vcl_only_r || slice_r) && (cnt_r != ORD_SAT)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      prefix_nxt = 1'b0;
      off_nxt    = 3'd0;
      slice_nxt  = 1'b0;
      aps_nxt    = 1'b0;
    end else if (!prefix_r && (off_r != OFF_MAX)) begin
      off_nxt = off_r + 3'd1;
    end

    // header byte
    hdr_off    = (codec_r == LAYOUT_VVC) ? HDR_OFF_VVC : HDR_OFF_SHORT;
    type_known = 1'b0;
    utype      = 6'd0;
    vslice     = 1'b0;
    ps_flag    = 1'b0;
    if (!prefix_nxt && (codec_r != LAYOUT_NONE) && (off_nxt == hdr_off)) begin
      type_known = 1'b1;
      unique case (codec_r)
        LAYOUT_AVC: begin
          utype  = {1'b0, e.data[4:0]};
          vslice = (utype < AVC_SLICE_LIM);
        end
        LAYOUT_HEVC: begin
          utype  = e.data[6:1];
          vslice = !utype[5];
        end
        LAYOUT_VVC: begin
          utype   = {1'b0, e.data[7:3]};
          vslice  = (utype < VVC_SLICE_LIM);
          ps_flag = (utype == VVC_APS_PRE) || (utype == VVC_APS_SUF);
        end
        default: type_known = 1'b0;
      endcase
      slice_nxt = vslice;
      aps_nxt   = ps_flag;
    end

    // APS identifier byte
    aps_known = !prefix_nxt && (codec_r == LAYOUT_VVC) && aps_nxt &&
                (off_nxt == APS_OFF_VVC);
    aps_id    = aps_known ? e.data : 8'd0;

    // window membership
    cnt_ext  = (WIN_W + 1)'(cnt_nxt);
    ws_ext   = (WIN_W + 1)'(win_start_r);
    wl_ext   = (WIN_W + 1)'(win_len_r);
    win_diff = cnt_ext - ws_ext;
    in_win   = !prefix_nxt && (cnt_ext >= ws_ext) && (win_diff < wl_ext);
    ord16    = prefix_nxt ? 16'd0 : 16'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 1'b1;
      off_r    <= 3'd0;
      cnt_r    <= '0;
      slice_r  <= 1'b0;
      aps_r    <= 1'b0;
    end else if (pop) begin
      if (e.final_b) begin
        // stream done: back to the reset stream state
        prefix_r <= 1'b1;
        off_r    <= 3'd0;
        cnt_r    <= '0;
        slice_r  <= 1'b0;
        aps_r    <= 1'b0;
      end else begin
        prefix_r <= prefix_nxt;
        off_r    <= off_nxt;
        cnt_r    <= cnt_nxt;
        slice_r  <= slice_nxt;
        aps_r    <= aps_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (pop) begin
      out_data_r <= {3'd0, aps_id, aps_known, ps_flag, vslice, utype, type_known,
                     in_win, ord16, prefix_nxt, e.start, e.data};
      out_last_r <= e.final_b;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_q_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 3'(QDEPTH))
    else $error("pending queue overflow");

  a_end_flush : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> fill_r == 2'd0)
    else $error("lookahead not flushed at stream end");

  a_start_in_unit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[8] |-> !out_data_r[9])
    else $error("start code word tagged as prefix");

  a_hdr_aps_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[27] && out_data_r[36]))
    else $error("header and APS id on the same word");

endmodule

/* tb/tb.sv */
// Self-checking testbench for annexb_nal_unit_scanner: Annex B byte streams in,
// tagged words out, each word predicted by a scoreboard and compared field by field.
// Depends on anxb_pkg (rtl/anxb_pkg.sv) and rtl/annexb_nal_unit_scanner.sv.
`timescale 1ns / 1ps

module tb;
  import anxb_pkg::*;

  // Output word layout, highest field first to match out_tdata
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] aps_ident;
    logic       aps_known;
    logic       param_set;
    logic       video_slice;
    logic [5:0] unit_type;
    logic       type_known;
    logic       inside_window;
    logic [15:0] unit_ordinal;
    logic       before_first;
    logic       unit_start;
    logic [7:0] data;
  } tag_word_t;

  typedef struct packed {
    logic      last;
    tag_word_t w;
  } tagged_byte_t;

  localparam logic [5:0] HEVC_SLICE_LIM = 6'd32;

  // Predicts the tagged words of the scanner and checks the words it emits
  class nal_scoreboard;
    codec_e_t        codec;
    bit              vcl_only;
    bit [15:0]       win_start;
    bit [15:0]       win_len;
    bit [7:0]        held[2];
    int unsigned     fill;
    bit [2:0]        unit_off;
    bit              in_prefix;
    bit              cur_slice;
    bit              cur_aps;
    bit [ORD_W-1:0]  units_done;
    tagged_byte_t    pending_q[$];
    int              errors;
    int              words_checked;
    int              bytes_noted;

    function new();
      codec     = LAYOUT_AVC;
      vcl_only  = 1'b0;
      win_start = 16'd0;
      win_len   = 16'd1;
      restart_stream();
    endfunction

    // Stream state goes back to its reset value; registers stay
    function void restart_stream();
      held[0]    = 8'h00;
      held[1]    = 8'h00;
      fill       = 0;
      unit_off   = 3'd0;
      in_prefix  = 1'b1;
      cur_slice  = 1'b0;
      cur_aps    = 1'b0;
      units_done = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [15:0] v);
      case (idx)
        REG_CODEC:     codec = codec_e_t'(v[1:0]);
        REG_VCL_ONLY:  vcl_only = v[0];
        REG_WIN_START: win_start = v;
        REG_WIN_LEN:   win_len = v;
        default: ;
      endcase
    endfunction

    // Tag one byte leaving the lookahead line
    function void tag_byte(bit [7:0] b, bit is_start, bit fin);
      tagged_byte_t    e;
      bit [2:0]        hdr_off;
      bit [5:0]        t;
      bit              slice;
      bit              aps;
      longint unsigned ord_l;
      e = '0;
      if (is_start) begin
        // previous unit is counted as it ends
        if (!in_prefix && (!vcl_only || cur_slice) && units_done != '1)
          units_done++;
        in_prefix = 1'b0;
        unit_off  = 3'd0;
        cur_slice = 1'b0;
        cur_aps   = 1'b0;
      end else if (!in_prefix && unit_off < OFF_MAX) begin
        unit_off++;
      end
      e.last           = fin;
      e.w.data         = b;
      e.w.unit_start   = is_start;
      e.w.before_first = in_prefix;
      if (!in_prefix) begin
        ord_l = units_done;
        e.w.unit_ordinal  = 16'(units_done);
        e.w.inside_window = (ord_l >= win_start) && (ord_l - win_start < win_len);
        hdr_off = (codec == LAYOUT_VVC) ? HDR_OFF_VVC : HDR_OFF_SHORT;
        if (codec != LAYOUT_NONE && unit_off == hdr_off) begin
          aps = 1'b0;
          case (codec)
            LAYOUT_AVC: begin
              t     = {1'b0, b[4:0]};
              slice = t < AVC_SLICE_LIM;
            end
            LAYOUT_HEVC: begin
              t     = b[6:1];
              slice = t < HEVC_SLICE_LIM;
            end
            default: begin
              t     = {1'b0, b[7:3]};
              slice = t < VVC_SLICE_LIM;
              aps   = (t == VVC_APS_PRE) || (t == VVC_APS_SUF);
            end
          endcase
          cur_slice         = slice;
          cur_aps           = aps;
          e.w.type_known    = 1'b1;
          e.w.unit_type     = t;
          e.w.video_slice   = slice;
          e.w.param_set     = aps;
        end
        if (codec == LAYOUT_VVC && cur_aps && unit_off == APS_OFF_VVC) begin
          e.w.aps_known = 1'b1;
          e.w.aps_ident = b;
        end
      end
      pending_q.push_back(e);
    endfunction

    // Accepted input byte: run the lookahead line and queue the words it releases
    function void note_byte(bit [7:0] b, bit last);
      bit [7:0] line[3];
      int       n;
      int       cnt;
      bit       st;
      bytes_noted++;
      line[0] = held[0];
      line[1] = held[1];
      line[2] = 8'h00;
      n = (fill > 2) ? 2 : fill;
      line[n] = b;
      n++;
      cnt = last ? n : ((n == 3) ? 1 : 0);
      for (int i = 0; i < cnt; i++) begin
        st = (i + 2 < n) && line[i] == 8'h00 && line[i+1] == 8'h00 && line[i+2] == 8'h01;
        tag_byte(line[i], st, last && (i + 1 == cnt));
      end
      if (last) begin
        restart_stream();
      end else if (n == 3) begin
        held[0] = line[1];
        held[1] = line[2];
        fill    = 2;
      end else begin
        held[0] = line[0];
        held[1] = (n > 1) ? line[1] : 8'h00;
        fill    = n;
      end
    endfunction

    function string field_diff(string name, logic [15:0] want, logic [15:0] got);
      return (want !== got) ? {name, " "} : "";
    endfunction

    // Compare an emitted word against the oldest prediction
    function void check_word(logic [47:0] d, logic last);
      tagged_byte_t e;
      tag_word_t    a;
      string        diffs;
      words_checked++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected word %h last %b", $time, d, last);
        return;
      end
      e = pending_q.pop_front();
      a = d;
      diffs = "";
      diffs = {diffs, field_diff("out_byte", 16'(e.w.data), 16'(a.data))};
      diffs = {diffs, field_diff("unit_start", 16'(e.w.unit_start), 16'(a.unit_start))};
      diffs = {diffs, field_diff("before_first_unit", 16'(e.w.before_first),
                                 16'(a.before_first))};
      diffs = {diffs, field_diff("unit_ordinal", e.w.unit_ordinal, a.unit_ordinal)};
      diffs = {diffs, field_diff("inside_window", 16'(e.w.inside_window),
                                 16'(a.inside_window))};
      diffs = {diffs, field_diff("type_known", 16'(e.w.type_known), 16'(a.type_known))};
      diffs = {diffs, field_diff("unit_type", 16'(e.w.unit_type), 16'(a.unit_type))};
      diffs = {diffs, field_diff("video_slice", 16'(e.w.video_slice),
                                 16'(a.video_slice))};
      diffs = {diffs, field_diff("param_set_flag", 16'(e.w.param_set), 16'(a.param_set))};
      diffs = {diffs, field_diff("aps_known", 16'(e.w.aps_known), 16'(a.aps_known))};
      diffs = {diffs, field_diff("aps_ident", 16'(e.w.aps_ident), 16'(a.aps_ident))};
      diffs = {diffs, field_diff("pad", 16'(e.w.pad), 16'(a.pad))};
      diffs = {diffs, field_diff("final_flag", 16'(e.last), 16'(last))};
      if (diffs != "") begin
        errors++;
        if (errors <= 10)
          $display("[%0t] word %0d mismatch: expected %h last %b, got %h last %b (%s)",
                   $time, words_checked, e.w, e.last, d, last, diffs);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [15:0]           cfg_data;

  nal_scoreboard sb;
  bit [7:0]      stream_buf[$];
  bit            quiet;
  bit            gaps_on;
  bit            hold_req;
  int            hold_left;
  int            stall_left;
  int            streams_sent;
  int            rand_bytes;

  annexb_nal_unit_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake monitor: inputs are noted before outputs are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        sb.check_word(out_tdata, out_tlast);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  // Receiver: random stall bursts plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = 59;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rst_n && !quiet && gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t with %0d words outstanding", $time, sb.pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_byte(bit [7:0] b, bit last);
    int gap;
    gap = (!quiet && gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Send stream_buf as one stream, tlast on its final byte
  task automatic send_stream();
    foreach (stream_buf[i])
      send_byte(stream_buf[i], i == stream_buf.size() - 1);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    streams_sent++;
  endtask

  task automatic write_cfg(cfg_reg_t idx, bit [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only once the scanner is drained and settled
  task automatic set_config(codec_e_t c, bit vcl, bit [15:0] ws, bit [15:0] wl);
    wait_drained();
    repeat (8) @(posedge clk);
    write_cfg(REG_CODEC, {14'd0, c});
    write_cfg(REG_VCL_ONLY, {15'd0, vcl});
    write_cfg(REG_WIN_START, ws);
    write_cfg(REG_WIN_LEN, wl);
  endtask

  function automatic bit [15:0] pick_window(bit [15:0] lo_max);
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, lo_max));
    endcase
  endfunction

  // Mostly well-formed streams of units with random content, some pure noise
  task automatic build_random_stream(codec_e_t c);
    int       units;
    bit [5:0] t;
    stream_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 16))
        case ($urandom_range(0, 3))
          0: stream_buf.push_back(8'h00);
          1: stream_buf.push_back(8'h01);
          default: stream_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      return;
    end
    repeat ($urandom_range(0, 2)) stream_buf.push_back(8'($urandom_range(1, 255)));
    units = $urandom_range(1, 3);
    repeat (units) begin
      if ($urandom_range(0, 3) == 0) stream_buf.push_back(8'h00);
      stream_buf.push_back(8'h00);
      stream_buf.push_back(8'h00);
      stream_buf.push_back(8'h01);
      // unit cut off before its header now and then
      if ($urandom_range(0, 7) != 0) begin
        case (c)
          LAYOUT_VVC: begin
            stream_buf.push_back(8'($urandom_range(0, 255)));
            t = ($urandom_range(0, 2) == 0) ? 6'(17 + $urandom_range(0, 1))
                                             : 6'($urandom_range(0, 31));
            stream_buf.push_back({t[4:0], 3'($urandom_range(0, 7))});
          end
          LAYOUT_HEVC: begin
            t = 6'($urandom_range(0, 63));
            stream_buf.push_back({1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1))});
            stream_buf.push_back(8'($urandom_range(0, 255)));
          end
          default: stream_buf.push_back(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 9))
          stream_buf.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      end
    end
    // trailing start code that the flush must not open
    if ($urandom_range(0, 7) == 0) begin
      stream_buf.push_back(8'h00);
      stream_buf.push_back(8'h00);
      stream_buf.push_back(8'h01);
    end
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    quiet        = 1'b0;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    streams_sent = 0;
    rand_bytes   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one-byte stream flushed at once
    stream_buf = '{8'h00};
    send_stream();
    // AVC at reset settings: leading junk, slice, short unit, non-slice,
    // and a start code at the very end that must not open a unit.
    // The receiver holds off meanwhile, so the queue fills and input stalls.
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    stream_buf = '{8'hAA, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01,
                   8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h01};
    send_stream();
    gaps_on  = 1'b1;
    // VVC adaptation parameter set with its id, offset past saturation, then a slice
    set_config(LAYOUT_VVC, 1'b1, 16'd1, 16'hFFFF);
    stream_buf = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h8B, 8'h5A, 8'h11, 8'h22, 8'h33,
                   8'h00, 8'h00, 8'h01, 8'h00, 8'h08};
    send_stream();

    // Random streams, each layout in turn, window registers mixing extremes
    for (int k = 0; rand_bytes < 60 || k < 4; k++) begin
      set_config(codec_e_t'(k % 4), 1'($urandom_range(0, 1)),
                 pick_window(16'd3), pick_window(16'd4));
      build_random_stream(codec_e_t'(k % 4));
      gaps_on = ($urandom_range(0, 3) != 0);
      quiet   = (rand_bytes >= 45) || (k >= 3);
      if (k == 1) hold_req = 1'b1;
      rand_bytes += stream_buf.size();
      send_stream();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d streams, %0d bytes in and %0d tagged words out,",
             streams_sent, sb.bytes_noted, sb.words_checked);
    $display("cycling through the four header layouts with random window registers");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
